[rtl/core/rigid_body_derived_data_core_macros.svh]
// assertion helpers for the rigid body core
`ifndef RIGID_BODY_DERIVED_DATA_CORE_MACROS_SVH
`define RIGID_BODY_DERIVED_DATA_CORE_MACROS_SVH
// a condition implies another in the same cycle
`define RBD_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("rbd check failed");
// a condition implies another in the next cycle
`define RBD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("rbd check failed");
`endif

[rtl/core/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// types and constants shared by the rigid body derived data core
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned NumRows = 6;

  localparam logic [2:0] RegXx = 3'd0;
  localparam logic [2:0] RegXy = 3'd1;
  localparam logic [2:0] RegXz = 3'd2;
  localparam logic [2:0] RegYy = 3'd3;
  localparam logic [2:0] RegYz = 3'd4;
  localparam logic [2:0] RegZz = 3'd5;

  localparam logic [2:0] RowLast = 3'd5;

  typedef struct packed {
    logic signed [31:0] quat_r;
    logic signed [31:0] quat_i;
    logic signed [31:0] quat_j;
    logic signed [31:0] quat_k;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } rbd_in_t;

  typedef struct packed {
    logic [2:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
  } rbd_out_t;

  // round (v / 2^30) on a signed 66 bit value
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    begin
      t = v + 66'sd536870912;
      return t[65:30] ;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    begin
      if (v > 40'sd2147483647) return 32'sh7fffffff;
      else if (v < -40'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

[rtl/core/rigid_body_derived_data_core.sv]
// a request passes through rbd_norm, rbd_rot and the rbd_emit queue before its first row
// the gap counter spaces requests to match the six rows each one sends on the output port
// busy stays high while the gap counter loaded by each request runs down and while the output queue is full
// rst_n is synchronous and clears all valid bits and counters, not the payload
// inertia registers reset to zero
// ----------------------------------------------------------------------------
// rigid_body_derived_data_core
// quaternion to transform and world inverse inertia tensor
// ----------------------------------------------------------------------------
module rigid_body_derived_data_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rbd_pkg::rbd_in_t  in_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  output logic              out_valid,
  output rbd_pkg::rbd_out_t out_data
);
  import rbd_pkg::*;

  logic signed [31:0] inv_r [6];
  logic               acc;
  logic [2:0]         gap_r;
  logic               n_vld, r_vld, q_full;
  logic signed [31:0] n_q [4];
  logic signed [31:0] n_pos [3], r_pos [3];
  logic signed [35:0] r_rm [3][3];
  logic signed [39:0] r_w [3][3];

  // spacing requests to the six rows sent per item keeps the queue drained
  assign busy = (gap_r != 3'd0) || q_full;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) inv_r[i] <= 32'sd0;
      gap_r <= 3'd0;
    end else begin
      if (cfg_we && cfg_index < 3'(NumRegs)) inv_r[cfg_index] <= cfg_wdata;
      if (acc) gap_r <= 3'(NumRows - 1);
      else if (gap_r != 3'd0) gap_r <= gap_r - 3'd1;
    end
  end

  rbd_norm u_norm (
    .clk(clk), .rst_n(rst_n), .in_vld(acc), .in_data(in_data),
    .out_vld(n_vld), .out_n(n_q), .out_pos(n_pos)
  );

  rbd_rot u_rot (
    .clk(clk), .rst_n(rst_n), .in_vld(n_vld), .in_n(n_q), .in_pos(n_pos),
    .inv_i(inv_r), .out_vld(r_vld), .out_rm(r_rm), .out_w(r_w), .out_pos(r_pos)
  );

  rbd_emit u_emit (
    .clk(clk), .rst_n(rst_n), .in_vld(r_vld), .in_rm(r_rm), .in_w(r_w),
    .in_pos(r_pos), .q_full(q_full), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

[rtl/core/rbd_norm.sv]
// ----------------------------------------------------------------------------
// rbd_norm
// quaternion normalization: scale, sum of squares, pipelined sqrt and divide
// ----------------------------------------------------------------------------
module rbd_norm (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  rbd_pkg::rbd_in_t       in_data,
  output logic                   out_vld,
  output logic signed [31:0]     out_n [4],
  output logic signed [31:0]     out_pos [3]
);
  import rbd_pkg::*;

  localparam int unsigned SqSteps = 32;  // one result bit per stage
  localparam int unsigned DivSteps = 32; // one quotient bit per stage

  // stage a: magnitudes
  logic        a_vld_r;
  logic [31:0] a_mag_r [4];
  logic [3:0]  a_neg_r;
  logic signed [31:0] a_pos_r [3];
  logic [31:0] q_raw [4];

  always_comb begin
    q_raw[0] = in_data.quat_r;
    q_raw[1] = in_data.quat_i;
    q_raw[2] = in_data.quat_j;
    q_raw[3] = in_data.quat_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
    for (int c = 0; c < 4; c++) begin
      a_neg_r[c] <= q_raw[c][31];
      a_mag_r[c] <= q_raw[c][31] ? (32'd0 - q_raw[c]) : q_raw[c];
    end
    a_pos_r[0] <= in_data.pos_x;
    a_pos_r[1] <= in_data.pos_y;
    a_pos_r[2] <= in_data.pos_z;
  end

  // stage b: scale by power of two
  logic        b_vld_r;
  logic [31:0] b_mag_r [4];
  logic [3:0]  b_neg_r;
  logic        b_zero_r;
  logic signed [31:0] b_pos_r [3];
  logic [31:0] mx_or;
  logic [4:0]  sh_amt;

  always_comb begin
    mx_or = a_mag_r[0] | a_mag_r[1] | a_mag_r[2] | a_mag_r[3];
    sh_amt = 5'd0;
    // shift needed so that top set bit reaches bit 29
    for (int b = 0; b < 30; b++) begin
      if (mx_or[b]) sh_amt = 5'(29 - b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_zero_r <= (mx_or == 32'd0);
    b_neg_r <= a_neg_r;
    b_pos_r <= a_pos_r;
    for (int c = 0; c < 4; c++) begin
      if (mx_or[31]) b_mag_r[c] <= a_mag_r[c] >> 1;
      else if (mx_or[30]) b_mag_r[c] <= a_mag_r[c];
      else b_mag_r[c] <= a_mag_r[c] << sh_amt;
    end
  end

  // stage c: squares
  logic        c_vld_r;
  logic [61:0] c_sq_r [4];
  logic [31:0] c_mag_r [4];
  logic [3:0]  c_neg_r;
  logic        c_zero_r;
  logic signed [31:0] c_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    for (int c = 0; c < 4; c++) begin
      c_sq_r[c] <= 62'(b_mag_r[c][30:0] * b_mag_r[c][30:0]);
    end
    c_mag_r <= b_mag_r;
    c_neg_r <= b_neg_r;
    c_zero_r <= b_zero_r;
    c_pos_r <= b_pos_r;
  end

  // stage d: sum
  logic        d_vld_r;
  logic [63:0] d_sum_r;
  logic [31:0] d_mag_r [4];
  logic [3:0]  d_neg_r;
  logic        d_zero_r;
  logic signed [31:0] d_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
    d_sum_r <= 64'(c_sq_r[0]) + 64'(c_sq_r[1]) + 64'(c_sq_r[2]) + 64'(c_sq_r[3]);
    d_mag_r <= c_mag_r;
    d_neg_r <= c_neg_r;
    d_zero_r <= c_zero_r;
    d_pos_r <= c_pos_r;
  end

  // square root pipeline, restoring, one bit per stage
  logic [SqSteps:0]   s_vld_r;
  logic [63:0]        s_rem_r  [SqSteps+1];
  logic [31:0]        s_root_r [SqSteps+1];
  logic [63:0]        s_x_r    [SqSteps+1];
  logic [31:0]        s_mag_r  [SqSteps+1][4];
  logic [3:0]         s_neg_r  [SqSteps+1];
  logic               s_zero_r [SqSteps+1];
  logic signed [31:0] s_pos_r  [SqSteps+1][3];

  always_comb begin
    s_vld_r[0]  = d_vld_r;
    s_rem_r[0]  = 64'd0;
    s_root_r[0] = 32'd0;
    s_x_r[0]    = d_sum_r;
    s_mag_r[0]  = d_mag_r;
    s_neg_r[0]  = d_neg_r;
    s_zero_r[0] = d_zero_r;
    s_pos_r[0]  = d_pos_r;
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    logic [65:0] rem_sh;
    logic [65:0] trial;
    always_comb begin
      rem_sh = {s_rem_r[g], s_x_r[g][63:62]};
      trial  = {32'd0, s_root_r[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[g+1] <= 1'b0;
      end else begin
        s_vld_r[g+1] <= s_vld_r[g];
      end
      if (rem_sh >= trial) begin
        s_rem_r[g+1]  <= 64'(rem_sh - trial);
        s_root_r[g+1] <= {s_root_r[g][30:0], 1'b1};
      end else begin
        s_rem_r[g+1]  <= rem_sh[63:0];
        s_root_r[g+1] <= {s_root_r[g][30:0], 1'b0};
      end
      s_x_r[g+1]    <= {s_x_r[g][61:0], 2'b00};
      s_mag_r[g+1]  <= s_mag_r[g];
      s_neg_r[g+1]  <= s_neg_r[g];
      s_zero_r[g+1] <= s_zero_r[g];
      s_pos_r[g+1]  <= s_pos_r[g];
    end
  end

  // divide pipeline: (a<<30 + m/2) / m for four lanes, one quotient bit a stage
  // dividend fits in 62 bits; quotient at most 2^31
  logic [DivSteps:0]  v_vld_r;
  logic [62:0]        v_num_r  [DivSteps+1][4];
  logic [32:0]        v_rem_r  [DivSteps+1][4];
  logic [31:0]        v_quo_r  [DivSteps+1][4];
  logic [31:0]        v_m_r    [DivSteps+1];
  logic [3:0]         v_neg_r  [DivSteps+1];
  logic               v_zero_r [DivSteps+1];
  logic signed [31:0] v_pos_r  [DivSteps+1][3];
  logic [31:0]        m_fin;

  // quotient high bits (above 31) are zero since a <= m; first 31 numerator
  // bits preloaded into the remainder
  always_comb begin
    m_fin = s_root_r[SqSteps];
    v_vld_r[0] = s_vld_r[SqSteps];
    v_m_r[0] = m_fin;
    v_neg_r[0] = s_neg_r[SqSteps];
    v_zero_r[0] = s_zero_r[SqSteps];
    v_pos_r[0] = s_pos_r[SqSteps];
    for (int c = 0; c < 4; c++) begin
      v_num_r[0][c] = {1'b0, s_mag_r[SqSteps][c], 30'd0} + 63'(m_fin >> 1);
      v_rem_r[0][c] = {2'b00, v_num_r[0][c][62:32]};
      v_quo_r[0][c] = 32'd0;
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [33:0] rs [4];
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        rs[c] = {v_rem_r[g][c], v_num_r[g][c][31 - g]};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_vld_r[g+1] <= 1'b0;
      end else begin
        v_vld_r[g+1] <= v_vld_r[g];
      end
      for (int c = 0; c < 4; c++) begin
        if (rs[c] >= {2'b00, v_m_r[g]}) begin
          v_rem_r[g+1][c] <= 33'(rs[c] - {2'b00, v_m_r[g]});
          v_quo_r[g+1][c] <= {v_quo_r[g][c][30:0], 1'b1};
        end else begin
          v_rem_r[g+1][c] <= rs[c][32:0];
          v_quo_r[g+1][c] <= {v_quo_r[g][c][30:0], 1'b0};
        end
      end
      v_num_r[g+1]  <= v_num_r[g];
      v_m_r[g+1]    <= v_m_r[g];
      v_neg_r[g+1]  <= v_neg_r[g];
      v_zero_r[g+1] <= v_zero_r[g];
      v_pos_r[g+1]  <= v_pos_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= v_vld_r[DivSteps];
    end
    for (int c = 0; c < 4; c++) begin
      if (v_zero_r[DivSteps]) begin
        out_n[c] <= (c == 0) ? 32'sh40000000 : 32'sd0;
      end else if (v_neg_r[DivSteps][c]) begin
        out_n[c] <= 32'sd0 - $signed(v_quo_r[DivSteps][c]);
      end else begin
        out_n[c] <= $signed(v_quo_r[DivSteps][c]);
      end
    end
    out_pos <= v_pos_r[DivSteps];
  end

endmodule

[rtl/core/rbd_rot.sv]
// ----------------------------------------------------------------------------
// rbd_rot
// rotation matrix from unit quaternion, then body tensor carried to world
// ----------------------------------------------------------------------------
module rbd_rot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] in_n [4],
  input  logic signed [31:0] in_pos [3],
  input  logic signed [31:0] inv_i [6],
  output logic               out_vld,
  output logic signed [35:0] out_rm [3][3],
  output logic signed [39:0] out_w [3][3],
  output logic signed [31:0] out_pos [3]
);
  import rbd_pkg::*;

  logic signed [31:0] im [3][3];

  always_comb begin
    im[0][0] = inv_i[RegXx]; im[0][1] = inv_i[RegXy]; im[0][2] = inv_i[RegXz];
    im[1][0] = inv_i[RegXy]; im[1][1] = inv_i[RegYy]; im[1][2] = inv_i[RegYz];
    im[2][0] = inv_i[RegXz]; im[2][1] = inv_i[RegYz]; im[2][2] = inv_i[RegZz];
  end

  // stage 1: ten quaternion products
  logic               p_vld_r;
  logic signed [63:0] p_ww_r, p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_xz_r, p_yz_r;
  logic signed [63:0] p_wx_r, p_wy_r, p_wz_r;
  logic signed [31:0] p_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= in_vld;
    end
    p_ww_r <= in_n[0] * in_n[0];
    p_xx_r <= in_n[1] * in_n[1];
    p_yy_r <= in_n[2] * in_n[2];
    p_zz_r <= in_n[3] * in_n[3];
    p_xy_r <= in_n[1] * in_n[2];
    p_xz_r <= in_n[1] * in_n[3];
    p_yz_r <= in_n[2] * in_n[3];
    p_wx_r <= in_n[0] * in_n[1];
    p_wy_r <= in_n[0] * in_n[2];
    p_wz_r <= in_n[0] * in_n[3];
    p_pos_r <= in_pos;
  end

  // stage 2: rotation elements rounded to Q6.30
  logic               r_vld_r;
  logic signed [35:0] r_m_r [3][3];
  logic signed [31:0] r_pos_r [3];
  logic signed [65:0] e [3][3];
  localparam logic signed [65:0] OneQ60 = 66'sd1 <<< 60;

  always_comb begin
    e[0][0] = OneQ60 - 66'(p_yy_r) * 2 - 66'(p_zz_r) * 2;
    e[0][1] = 66'(p_xy_r) * 2 - 66'(p_wz_r) * 2;
    e[0][2] = 66'(p_xz_r) * 2 + 66'(p_wy_r) * 2;
    e[1][0] = 66'(p_xy_r) * 2 + 66'(p_wz_r) * 2;
    e[1][1] = OneQ60 - 66'(p_xx_r) * 2 - 66'(p_zz_r) * 2;
    e[1][2] = 66'(p_yz_r) * 2 - 66'(p_wx_r) * 2;
    e[2][0] = 66'(p_xz_r) * 2 - 66'(p_wy_r) * 2;
    e[2][1] = 66'(p_yz_r) * 2 + 66'(p_wx_r) * 2;
    e[2][2] = OneQ60 - 66'(p_xx_r) * 2 - 66'(p_yy_r) * 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= p_vld_r;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        r_m_r[a][b] <= rnd30(e[a][b]);
      end
    end
    r_pos_r <= p_pos_r;
  end

  // stage 3: products R*I, 27 of them
  logic               t_vld_r;
  logic signed [35:0] t_p_r [3][3][3];
  logic signed [35:0] t_m_r [3][3];
  logic signed [31:0] t_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= r_vld_r;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int k = 0; k < 3; k++) begin
          t_p_r[a][b][k] <= rnd30(66'(r_m_r[a][k] * im[k][b]));
        end
      end
    end
    t_m_r <= r_m_r;
    t_pos_r <= r_pos_r;
  end

  // stage 4: T sums
  logic               u_vld_r;
  logic signed [37:0] u_t_r [3][3];
  logic signed [35:0] u_m_r [3][3];
  logic signed [31:0] u_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_vld_r <= 1'b0;
    end else begin
      u_vld_r <= t_vld_r;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        u_t_r[a][b] <= 38'(t_p_r[a][b][0]) + 38'(t_p_r[a][b][1]) + 38'(t_p_r[a][b][2]);
      end
    end
    u_m_r <= t_m_r;
    u_pos_r <= t_pos_r;
  end

  // stage 5: products T*R^T
  logic               x_vld_r;
  logic signed [35:0] x_p_r [3][3][3];
  logic signed [35:0] x_m_r [3][3];
  logic signed [31:0] x_pos_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else begin
      x_vld_r <= u_vld_r;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int k = 0; k < 3; k++) begin
          x_p_r[a][b][k] <= rnd30(66'(u_t_r[a][k] * u_m_r[b][k]));
        end
      end
    end
    x_m_r <= u_m_r;
    x_pos_r <= u_pos_r;
  end

  // stage 6: W sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= x_vld_r;
    end
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        out_w[a][b] <= 40'(x_p_r[a][b][0]) + 40'(x_p_r[a][b][1]) + 40'(x_p_r[a][b][2]);
      end
    end
    out_rm <= x_m_r;
    out_pos <= x_pos_r;
  end

endmodule

[rtl/core/rbd_emit.sv]
// ----------------------------------------------------------------------------
// rbd_emit
// holds finished items in a small queue and sends six rows per item
// ----------------------------------------------------------------------------
module rbd_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [35:0] in_rm [3][3],
  input  logic signed [39:0] in_w [3][3],
  input  logic signed [31:0] in_pos [3],
  output logic               q_full,
  output logic               out_valid,
  output rbd_pkg::rbd_out_t  out_data
);
  import rbd_pkg::*;

  // rows of one item, packed into 4 cols each
  typedef logic [127:0] rowset_t [6];

  localparam int unsigned Depth = 2;

  rowset_t     mem_r [Depth];
  logic [0:0]  wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic [2:0]  row_r;
  rowset_t     rs;
  logic        pop;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rs[a] = {sat32(40'(in_rm[a][0] >>> 14) + 40'(in_rm[a][0][13])),
               sat32(40'(in_rm[a][1] >>> 14) + 40'(in_rm[a][1][13])),
               sat32(40'(in_rm[a][2] >>> 14) + 40'(in_rm[a][2][13])),
               in_pos[a]};
      rs[a + 3] = {sat32(in_w[a][0]), sat32(in_w[a][1]), sat32(in_w[a][2]), 32'd0};
    end
    pop = (cnt_r != 2'd0) && (row_r == RowLast);
  end

  assign q_full = (cnt_r == 2'(Depth));
  assign out_valid = (cnt_r != 2'd0);

  always_comb begin
    out_data.row_index = row_r;
    out_data.col0 = mem_r[rp_r][row_r][127:96];
    out_data.col1 = mem_r[rp_r][row_r][95:64];
    out_data.col2 = mem_r[rp_r][row_r][63:32];
    out_data.col3 = mem_r[rp_r][row_r][31:0];
    out_data.last_row = (row_r == RowLast);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      row_r <= 3'd0;
    end else begin
      if (in_vld) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(in_vld) - 2'(pop);
      if (cnt_r != 2'd0) row_r <= (row_r == RowLast) ? 3'd0 : row_r + 3'd1;
    end
    if (in_vld) mem_r[wp_r] <= rs;
  end

endmodule

[rtl/core/rbd_checker.sv]
// ----------------------------------------------------------------------------
// rbd_checker
// port level checks for the rigid body derived data core
// ----------------------------------------------------------------------------
`include "rigid_body_derived_data_core_macros.svh"
module rbd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rbd_pkg::rbd_out_t out_data
);
  import rbd_pkg::*;

  `RBD_ASSERT_IMP(a_row_range, clk, rst_n, out_valid, out_data.row_index <= RowLast)
  `RBD_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, out_data.last_row == (out_data.row_index == RowLast))
  `RBD_ASSERT_NEXT(a_row_step, clk, rst_n, out_valid && !out_data.last_row, out_valid && out_data.row_index == $past(out_data.row_index) + 3'd1)
  `RBD_ASSERT_NEXT(a_spacing, clk, rst_n, start && !busy, busy)

endmodule

bind rigid_body_derived_data_core rbd_checker u_rbd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
